/* rtl/gblur_pkg.sv */
`default_nettype none
package gblur_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int KSIZE      = 5;

   localparam int PIX_W  = 8;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int CSR_W  = 13;
   localparam int CIDX_W = 2;

   // one line-store word holds the four older lines of one column, oldest in the low byte
   localparam int LS_W = (KSIZE - 1) * PIX_W;

   localparam logic [CIDX_W-1:0] CSR_FRAME_WIDTH  = CIDX_W'(0);
   localparam logic [CIDX_W-1:0] CSR_FRAME_HEIGHT = CIDX_W'(1);

   typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
   } tag_type;

endpackage
`default_nettype wire

/* rtl/gblur_ram.sv */
`default_nettype none
module gblur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/gblur_window.sv */
`default_nettype none
module gblur_window import gblur_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             acc,
   input  wire logic [PIX_W-1:0] acc_pixel,
   input  wire logic [COL_W-1:0] acc_col,
   input  wire tag_type          acc_tag,
   output logic                  win_valid,
   output window_type            win,
   output tag_type               win_tag
);

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   tag_type          s1_tag_ff;
   logic [LS_W-1:0]  ls_rd_data;
   logic [LS_W-1:0]  ls_wr_data;
   logic             ls_wr_en;
   logic [KSIZE-1:0][PIX_W-1:0] new_col;

   window_type       win_ff, win_in;
   logic             win_valid_ff, win_valid_in;
   tag_type          win_tag_ff;

   // read is issued on accept; the shifted column is written back from s1
   gblur_ram #(
      .WIDTH(LS_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ls_wr_en),
      .wr_addr(s1_col_ff),
      .wr_data(ls_wr_data),
      .rd_en  (en),
      .rd_addr(acc_col),
      .rd_data(ls_rd_data)
   );

   assign ls_wr_en   = en && s1_valid_ff;
   assign ls_wr_data = {s1_pixel_ff, ls_rd_data[LS_W-1:PIX_W]};
   assign s1_valid_in = acc;

   always_comb begin
      for (int r = 0; r < KSIZE - 1; r++) begin
         new_col[r] = ls_rd_data[r*PIX_W +: PIX_W];
      end
      new_col[KSIZE-1] = s1_pixel_ff;
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE - 1; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
         win_in[r][KSIZE-1] = new_col[r];
      end
   end

   assign win_valid_in = s1_valid_ff && s1_tag_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else if (en) begin
         s1_valid_ff  <= s1_valid_in;
         win_valid_ff <= win_valid_in;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (acc) begin
            s1_pixel_ff <= acc_pixel;
            s1_col_ff   <= acc_col;
            s1_tag_ff   <= acc_tag;
         end
         if (s1_valid_ff) begin
            win_tag_ff <= s1_tag_ff;
         end
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign win_tag   = win_tag_ff;

endmodule
`default_nettype wire

/* rtl/gblur_filter.sv */
`default_nettype none
module gblur_filter import gblur_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       win_valid,
   input  wire window_type win,
   input  wire tag_type    win_tag,
   output logic            rsp_valid,
   output logic [PIX_W-1:0] rsp_blurred_value,
   output logic [COL_W-1:0] rsp_out_x,
   output logic [ROW_W-1:0] rsp_out_y,
   output logic            rsp_last_of_frame
);

   localparam int RS_W  = PIX_W + 4;
   localparam int SUM_W = RS_W + 4;

   // 1-4-6-4-1 taps as shifts and adds
   function automatic logic [RS_W-1:0] row_tap(input logic [KSIZE-1:0][PIX_W-1:0] v);
      logic [RS_W-1:0] a0, a1, a2, a3, a4;
      a0 = RS_W'(v[0]);
      a1 = RS_W'(v[1]);
      a2 = RS_W'(v[2]);
      a3 = RS_W'(v[3]);
      a4 = RS_W'(v[4]);
      return a0 + (a1 << 2) + (a2 << 2) + (a2 << 1) + (a3 << 2) + a4;
   endfunction

   function automatic logic [SUM_W-1:0] col_tap(input logic [KSIZE-1:0][RS_W-1:0] v);
      logic [SUM_W-1:0] a0, a1, a2, a3, a4;
      a0 = SUM_W'(v[0]);
      a1 = SUM_W'(v[1]);
      a2 = SUM_W'(v[2]);
      a3 = SUM_W'(v[3]);
      a4 = SUM_W'(v[4]);
      return a0 + (a1 << 2) + (a2 << 2) + (a2 << 1) + (a3 << 2) + a4;
   endfunction

   logic [KSIZE-1:0][RS_W-1:0] rs_ff, rs_in;
   logic                       rs_valid_ff;
   tag_type                    rs_tag_ff;
   logic [SUM_W-1:0]           sum;
   logic                       out_valid_ff;
   logic [PIX_W-1:0]           out_value_ff;
   tag_type                    out_tag_ff;

   always_comb begin
      for (int r = 0; r < KSIZE; r++) begin
         rs_in[r] = row_tap(win[r]);
      end
   end

   assign sum = col_tap(rs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         rs_valid_ff  <= win_valid;
         out_valid_ff <= rs_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (win_valid) begin
            rs_ff     <= rs_in;
            rs_tag_ff <= win_tag;
         end
         if (rs_valid_ff) begin
            out_value_ff <= sum[SUM_W-1 -: PIX_W];
            out_tag_ff   <= rs_tag_ff;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blurred_value = out_value_ff;
   assign rsp_out_x         = out_tag_ff.x;
   assign rsp_out_y         = out_tag_ff.y;
   assign rsp_last_of_frame = out_tag_ff.last;

endmodule
`default_nettype wire

/* rtl/gaussian_blur_5x5_stream.sv */
`default_nettype none
// 5x5 binomial blur over a raster stream of 8-bit gray pixels. One pixel word is
// taken per clock while req_stall is low; a result leaves on rsp through the s1,
// window, row-sum and output registers after the pixel that completes its window
// (the one two columns right and two rows below it), and only interior pixels give
// a result. The single 1024 x 32 line-store RAM is read on accept and written back
// from the s1 registers; the whole pipeline holds while rsp_stall is high with a
// result waiting, so req_stall follows it. Writing either frame register restarts
// the frame at column and row zero; do it with the pipe empty.
module gaussian_blur_5x5_stream import gblur_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [CIDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  req_pixel_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PIX_W-1:0]       rsp_blurred_value,
   output logic [COL_W-1:0]       rsp_out_x,
   output logic [ROW_W-1:0]       rsp_out_y,
   output logic                   rsp_last_of_frame
);

   localparam logic [COL_W-1:0] RESET_W_LAST = COL_W'(639);
   localparam logic [ROW_W-1:0] RESET_H_LAST = ROW_W'(479);

   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             en, acc;
   logic [FW_W-1:0]  fw;
   logic [FH_W-1:0]  fh;
   tag_type          acc_tag;
   logic             win_valid;
   window_type       win;
   tag_type          win_tag;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;
   assign acc       = req_valid && en;

   // clamp on write, keep width-1 and height-1
   always_comb begin
      fw = csr_wdata[FW_W-1:0];
      fh = csr_wdata[FH_W-1:0];
      if (fw < FW_W'(KSIZE)) begin
         w_last_in = COL_W'(KSIZE - 1);
      end else if (fw > FW_W'(MAX_WIDTH)) begin
         w_last_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last_in = COL_W'(fw - FW_W'(1));
      end
      if (fh < FH_W'(KSIZE)) begin
         h_last_in = ROW_W'(KSIZE - 1);
      end else if (fh > FH_W'(MAX_HEIGHT)) begin
         h_last_in = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last_in = ROW_W'(fh - FH_W'(1));
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign acc_tag.emit = (col_ff >= COL_W'(KSIZE - 1)) && (row_ff >= ROW_W'(KSIZE - 1));
   assign acc_tag.last = (col_ff == w_last_ff) && (row_ff == h_last_ff);
   assign acc_tag.x    = col_ff - COL_W'(2);
   assign acc_tag.y    = row_ff - ROW_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= RESET_W_LAST;
         h_last_ff <= RESET_H_LAST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wen && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            w_last_ff <= w_last_in;
         end else begin
            h_last_ff <= h_last_in;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   gblur_window u_window (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .acc      (acc),
      .acc_pixel(req_pixel_value),
      .acc_col  (col_ff),
      .acc_tag  (acc_tag),
      .win_valid(win_valid),
      .win      (win),
      .win_tag  (win_tag)
   );

   gblur_filter u_filter (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .win_valid        (win_valid),
      .win              (win),
      .win_tag          (win_tag),
      .rsp_valid        (rsp_valid),
      .rsp_blurred_value(rsp_blurred_value),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last_ff)
      else $error("column count past line end");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last_ff)
      else $error("row count past frame end");

   a_out_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_x >= COL_W'(2)) && (rsp_out_x <= COL_W'(MAX_WIDTH - 3))
                    && (rsp_out_y >= ROW_W'(2)) && (rsp_out_y <= ROW_W'(MAX_HEIGHT - 3)))
      else $error("result outside interior");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(col_ff) || $past(csr_wen))
      else $error("pixel taken while output blocked");

endmodule
`default_nettype wire
